// ===== src/mdp_pkg.sv =====
// Shared constants and types for the Mestel disk potential evaluator.
package mdp_pkg;

    localparam int NORM_STEPS = 6;
    localparam int LOG_BITS   = 32;
    localparam int QBITS      = 32;
    localparam int LG_LAT     = NORM_STEPS + LOG_BITS + 5;
    localparam int DV_LAT     = QBITS + 2;
    localparam int PAD_LAT    = LG_LAT - DV_LAT;

    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } res_t;

endpackage

// ===== src/mestel_disk_potential_eval.sv =====
// Top level of the Mestel disk potential and acceleration evaluator.
//
// Input channel (in_valid/in_ready) takes one beat per position: pos_x,
// pos_y and axis_count. Output channel (out_valid/out_ready) gives one beat
// per input: potential = vc2*ln(r), accel_x/accel_y = -vc2*pos/r^2, all
// signed fixed point with FRAC_BITS fraction bits, plus at_origin and
// saturated flags. The config channel (cfg_valid/cfg_ready/cfg_data) writes
// vc_squared; write it only while no beat is in flight.
// From input beat to output beat a beat passes the square registers, the r^2
// sum register, the log path (6 normalize stages, 32 squaring stages, 5
// scaling stages) and one output register. The dividers take 34 stages
// and are delay-matched to the log path.
// Throughput is one beat per cycle. When out_ready is low with a result
// held, the whole pipeline holds and in_ready drops; nothing is lost.
// Reset clears all valid bits and loads vc_squared with 1.0.
module mestel_disk_potential_eval
    import mdp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [1:0]  axis_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] potential,
    output logic [31:0] accel_x,
    output logic [31:0] accel_y,
    output logic        at_origin,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic        en;
    logic [31:0] vc_squared_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_squared_reg <= 32'(64'd1 << FRAC_BITS);
        else if (cfg_valid)
            vc_squared_reg <= cfg_data;
    end

    logic [31:0] xm;
    logic [31:0] ym;
    logic [31:0] xe;
    logic [31:0] ye;
    logic        use1;
    logic        use2;

    assign xm   = pos_x[31] ? (~pos_x + 32'd1) : pos_x;
    assign ym   = pos_y[31] ? (~pos_y + 32'd1) : pos_y;
    assign use1 = (axis_count != 2'd0);
    assign use2 = axis_count[1];
    assign xe   = use1 ? xm : 32'd0;
    assign ye   = use2 ? ym : 32'd0;

    logic [63:0] xsq_reg;
    logic [63:0] ysq_reg;
    logic [63:0] px1_reg;
    logic [63:0] py1_reg;
    logic        xn1_reg;
    logic        yn1_reg;
    logic        u21_reg;
    logic        v1_reg;
    logic [63:0] r2_reg;
    logic [63:0] px2_reg;
    logic [63:0] py2_reg;
    logic        xn2_reg;
    logic        yn2_reg;
    logic        u22_reg;
    logic        z2_reg;
    logic        v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xsq_reg <= 64'(xe) * 64'(xe);
            ysq_reg <= 64'(ye) * 64'(ye);
            px1_reg <= 64'(vc_squared_reg) * 64'(xm);
            py1_reg <= 64'(vc_squared_reg) * 64'(ym);
            xn1_reg <= pos_x[31];
            yn1_reg <= pos_y[31];
            u21_reg <= use2;
            r2_reg  <= xsq_reg + ysq_reg;
            z2_reg  <= (xsq_reg + ysq_reg) == 64'd0;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            xn2_reg <= xn1_reg;
            yn2_reg <= yn1_reg;
            u22_reg <= u21_reg;
        end
    end

    res_t lg_res;
    res_t dx_res;
    res_t dy_res;

    mdp_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk (clk),
        .en  (en),
        .r2  (r2_reg),
        .vc  (vc_squared_reg),
        .res (lg_res)
    );

    mdp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (px2_reg),
        .den (r2_reg),
        .neg (!xn2_reg),
        .res (dx_res)
    );

    mdp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (py2_reg),
        .den (r2_reg),
        .neg (!yn2_reg),
        .res (dy_res)
    );

    res_t dxd_reg [PAD_LAT];
    res_t dyd_reg [PAD_LAT];
    logic u2d_reg [LG_LAT];
    logic zd_reg  [LG_LAT];
    logic vd_reg  [LG_LAT];

    genvar k;
    generate
        for (k = 0; k < PAD_LAT; k++) begin : g_pad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dxd_reg[k] <= (k == 0) ? dx_res : dxd_reg[(k == 0) ? 0 : k-1];
                    dyd_reg[k] <= (k == 0) ? dy_res : dyd_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
        for (k = 0; k < LG_LAT; k++) begin : g_side
            logic usrc;
            logic zsrc;
            logic vsrc;
            if (k == 0) begin : g_first
                assign usrc = u22_reg;
                assign zsrc = z2_reg;
                assign vsrc = v2_reg;
            end
            else begin : g_rest
                assign usrc = u2d_reg[k-1];
                assign zsrc = zd_reg[k-1];
                assign vsrc = vd_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    u2d_reg[k] <= usrc;
                    zd_reg[k]  <= zsrc;
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vd_reg[k] <= 1'b0;
                else if (en)
                    vd_reg[k] <= vsrc;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= vd_reg[LG_LAT-1];
        end
    end

    res_t fx;
    res_t fy;
    logic fz;
    logic fu2;

    assign fx  = dxd_reg[PAD_LAT-1];
    assign fy  = dyd_reg[PAD_LAT-1];
    assign fz  = zd_reg[LG_LAT-1];
    assign fu2 = u2d_reg[LG_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            potential <= fz ? 32'd0 : lg_res.val;
            accel_x   <= fz ? 32'd0 : fx.val;
            accel_y   <= (fz || !fu2) ? 32'd0 : fy.val;
            at_origin <= fz;
            saturated <= !fz && (lg_res.sat || fx.sat || (fu2 && fy.sat));
        end
    end

endmodule

// ===== src/mdp_log.sv =====
// Pipelined vc2 * ln(sqrt(r2)) unit: normalize, log2 by squaring, scale.
module mdp_log
    import mdp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] r2,
    input  logic [31:0] vc,
    output res_t        res
);

    logic [63:0] nm_reg  [NORM_STEPS];
    logic [5:0]  cnt_reg [NORM_STEPS];

    genvar k;
    generate
        for (k = 0; k < NORM_STEPS; k++) begin : g_norm
            localparam int SH = 32 >> k;
            logic [63:0] src;
            logic [5:0]  csrc;
            if (k == 0) begin : g_first
                assign src  = r2;
                assign csrc = '0;
            end
            else begin : g_rest
                assign src  = nm_reg[k-1];
                assign csrc = cnt_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (src[63 -: SH] == '0)
                    begin
                        nm_reg[k]  <= src << SH;
                        cnt_reg[k] <= csrc + 6'(SH);
                    end
                    else
                    begin
                        nm_reg[k]  <= src;
                        cnt_reg[k] <= csrc;
                    end
                end
            end
        end
    endgenerate

    logic [31:0] m_reg  [LOG_BITS];
    logic [31:0] fr_reg [LOG_BITS];
    logic [5:0]  pc_reg [LOG_BITS];

    generate
        for (k = 0; k < LOG_BITS; k++) begin : g_sq
            logic [31:0] msrc;
            logic [31:0] fsrc;
            logic [5:0]  csrc;
            logic [63:0] sq;
            if (k == 0) begin : g_first
                assign msrc = nm_reg[NORM_STEPS-1][63:32];
                assign fsrc = '0;
                assign csrc = cnt_reg[NORM_STEPS-1];
            end
            else begin : g_rest
                assign msrc = m_reg[k-1];
                assign fsrc = fr_reg[k-1];
                assign csrc = pc_reg[k-1];
            end
            assign sq = 64'(msrc) * 64'(msrc);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k]  <= sq[63] ? sq[63:32] : sq[62:31];
                    fr_reg[k] <= {fsrc[30:0], sq[63]};
                    pc_reg[k] <= csrc;
                end
            end
        end
    endgenerate

    localparam logic [6:0] TWO_F = 7'(2 * FRAC_BITS);

    logic [6:0]  p_pos;
    logic [37:0] lmag_next;
    logic        lneg_next;
    logic [37:0] lmag_reg;
    logic [3:0]  lneg_reg;
    logic [63:0] lo_reg;
    logic [37:0] hi_reg;
    logic [69:0] prod;
    logic [36:0] lnr_reg;
    logic [63:0] a_reg;
    logic [36:0] b_reg;
    logic [68:0] s_sum;
    logic [36:0] pm;
    logic [36:0] lim;
    logic [36:0] pv;
    logic        psat;
    res_t        res_reg;
    res_t        res_next;

    always_comb
    begin
        p_pos     = 7'd63 - 7'(pc_reg[LOG_BITS-1]);
        lneg_next = (p_pos < TWO_F);
        if (!lneg_next)
            lmag_next = {6'(p_pos - TWO_F), fr_reg[LOG_BITS-1]};
        else
            lmag_next = {6'(TWO_F - p_pos), 32'd0} - {6'd0, fr_reg[LOG_BITS-1]};
    end

    assign prod  = {6'd0, lo_reg} + {hi_reg, 32'd0};
    assign s_sum = {5'd0, a_reg} + {b_reg, 32'd0};
    assign pm    = s_sum[68:32];

    always_comb
    begin
        lim          = lneg_reg[3] ? 37'h0_8000_0000 : 37'h0_7FFF_FFFF;
        psat         = (pm > lim);
        pv           = psat ? lim : pm;
        res_next.sat = psat;
        res_next.val = lneg_reg[3] ? (~pv[31:0] + 32'd1) : pv[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lmag_reg <= lmag_next;
            lneg_reg <= {lneg_reg[2:0], lneg_next};
            lo_reg   <= 64'(lmag_reg[31:0]) * 64'(LN2_Q32);
            hi_reg   <= 38'(lmag_reg[37:32]) * 38'(LN2_Q32);
            lnr_reg  <= prod[69:33];
            a_reg    <= 64'(vc) * 64'(lnr_reg[31:0]);
            b_reg    <= 37'(vc) * 37'(lnr_reg[36:32]);
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== src/mdp_div.sv =====
// Pipelined restoring divider: saturated floor(num * 2^FRAC_BITS / den), signed.
module mdp_div
    import mdp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  logic        neg,
    output res_t        res
);

    localparam int W = 64 + QBITS;

    logic [W-1:0]   rem0_reg;
    logic [63:0]    den0_reg;
    logic           ov0_reg;
    logic           neg0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= W'(num) << FRAC_BITS;
            den0_reg <= den;
            ov0_reg  <= (W'(num) >= (W'(den) << (QBITS - FRAC_BITS)));
            neg0_reg <= neg;
        end
    end

    logic [W-1:0]     rem_reg [QBITS];
    logic [63:0]      den_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS];
    logic             ov_reg  [QBITS];
    logic             neg_reg [QBITS];

    genvar k;
    generate
        for (k = 0; k < QBITS; k++) begin : g_step
            localparam int B = QBITS - 1 - k;
            logic [W-1:0]     rsrc;
            logic [63:0]      dsrc;
            logic [QBITS-1:0] qsrc;
            logic             osrc;
            logic             nsrc;
            logic [W-1:0]     dsh;
            logic             take;
            if (k == 0) begin : g_first
                assign rsrc = rem0_reg;
                assign dsrc = den0_reg;
                assign qsrc = '0;
                assign osrc = ov0_reg;
                assign nsrc = neg0_reg;
            end
            else begin : g_rest
                assign rsrc = rem_reg[k-1];
                assign dsrc = den_reg[k-1];
                assign qsrc = q_reg[k-1];
                assign osrc = ov_reg[k-1];
                assign nsrc = neg_reg[k-1];
            end
            assign dsh  = W'(dsrc) << B;
            assign take = (rsrc >= dsh);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rsrc - dsh) : rsrc;
                    den_reg[k] <= dsrc;
                    q_reg[k]   <= {qsrc[QBITS-2:0], take};
                    ov_reg[k]  <= osrc;
                    neg_reg[k] <= nsrc;
                end
            end
        end
    endgenerate

    logic [31:0] lim;
    logic [31:0] qv;
    logic        qsat;
    res_t        res_reg;
    res_t        res_next;

    always_comb
    begin
        lim          = neg_reg[QBITS-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qsat         = ov_reg[QBITS-1] || (q_reg[QBITS-1] > lim);
        qv           = qsat ? lim : q_reg[QBITS-1];
        res_next.sat = qsat;
        res_next.val = neg_reg[QBITS-1] ? (~qv + 32'd1) : qv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
